@@ rtl/tch_pkg.sv @@
package tch_pkg;

   // Angle resolution of the heading and number of CORDIC rotations.
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int CORDIC_STAGES   = 16;

   // Field and datapath widths.
   localparam int SAMPLE_W  = 16;
   localparam int HEADING_W = 9 + ANGLE_FRAC_BITS;
   localparam int MAG_W     = 19;
   localparam int RAD_W     = 32;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int XY_W      = 56;
   localparam int ZFRAC     = 20;
   localparam int Z_W       = 30;
   localparam int HR_W      = Z_W - (ZFRAC - ANGLE_FRAC_BITS);
   localparam int CSR_IDX_W = 3;

   localparam int HEAD_FULL   = 360 << ANGLE_FRAC_BITS;
   localparam int Z_HALF_TURN = 180 << ZFRAC;
   localparam int Z_ROUND     = 1 << (ZFRAC - 1 - ANGLE_FRAC_BITS);
   localparam int SCALE_ONE   = 16384;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Pipeline depth of the back end: square root, three multiply stages,
   // CORDIC set-up, the rotations and the output register.
   localparam int BACK_DEPTH = ROOT_W + 3 + 1 + CORDIC_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X = 3'd0,
      CSR_OFFSET_Y = 3'd1,
      CSR_OFFSET_Z = 3'd2,
      CSR_SCALE_X  = 3'd3,
      CSR_SCALE_Y  = 3'd4,
      CSR_SCALE_Z  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] offset_x;
      logic signed [SAMPLE_W-1:0] offset_y;
      logic signed [SAMPLE_W-1:0] offset_z;
      logic [SAMPLE_W-1:0]        scale_x;
      logic [SAMPLE_W-1:0]        scale_y;
      logic [SAMPLE_W-1:0]        scale_z;
   } cfg_type;

   // One classified sample set as it waits between front and back.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ax;
      logic signed [SAMPLE_W-1:0] ay;
      logic signed [SAMPLE_W-1:0] az;
      logic signed [MAG_W-1:0]    mx;
      logic signed [MAG_W-1:0]    my;
      logic signed [MAG_W-1:0]    mz;
      logic [RAD_W-1:0]           n2;
      logic [RAD_W-1:0]           r2;
      logic                       degen;
   } q_item_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   clear;
      logic                   degen;
   } cordic_type;

   // atan(2^-i) in units of 2^-20 degree, rounded.
   function automatic logic signed [Z_W-1:0] atan_q20(input int unsigned idx);
      logic signed [Z_W-1:0] a;
      unique case (idx)
         0:  a = 30'sd47185920;
         1:  a = 30'sd27855475;
         2:  a = 30'sd14718068;
         3:  a = 30'sd7471121;
         4:  a = 30'sd3750058;
         5:  a = 30'sd1876857;
         6:  a = 30'sd938658;
         7:  a = 30'sd469357;
         8:  a = 30'sd234682;
         9:  a = 30'sd117342;
         10: a = 30'sd58671;
         11: a = 30'sd29335;
         12: a = 30'sd14668;
         13: a = 30'sd7334;
         14: a = 30'sd3667;
         15: a = 30'sd1833;
         16: a = 30'sd917;
         17: a = 30'sd458;
         18: a = 30'sd229;
         19: a = 30'sd115;
         20: a = 30'sd57;
         21: a = 30'sd29;
         22: a = 30'sd14;
         23: a = 30'sd7;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

@@ rtl/tch_front.sv @@
module tch_front import tch_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic signed [SAMPLE_W-1:0] req_mag_x,
   input  logic signed [SAMPLE_W-1:0] req_mag_y,
   input  logic signed [SAMPLE_W-1:0] req_mag_z,
   input  cfg_type                    cfg,
   input  logic                       q_full,
   output logic                       q_push,
   output q_item_type                 q_item
);

   logic                       vld_ff, vld_in;
   logic signed [SAMPLE_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [33:0]         px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [31:0]         sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic signed [16:0]         dx, dy, dz, sx, sy, sz;
   logic [RAD_W-1:0]           r2, n2;
   logic                       take;

   assign take      = req_valid && req_ready;
   assign req_ready = !vld_ff || !q_full;
   assign q_push    = vld_ff && !q_full;

   // Hard-iron offset removal and the products for the soft-iron scale and squares.
   always_comb begin
      dx     = 17'(req_mag_x) - 17'(cfg.offset_x);
      dy     = 17'(req_mag_y) - 17'(cfg.offset_y);
      dz     = 17'(req_mag_z) - 17'(cfg.offset_z);
      sx     = $signed({1'b0, cfg.scale_x});
      sy     = $signed({1'b0, cfg.scale_y});
      sz     = $signed({1'b0, cfg.scale_z});
      px_in  = dx * sx;
      py_in  = dy * sy;
      pz_in  = dz * sz;
      sqx_in = req_accel_x * req_accel_x;
      sqy_in = req_accel_y * req_accel_y;
      sqz_in = req_accel_z * req_accel_z;
   end

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (q_push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ax_ff  <= req_accel_x;
         ay_ff  <= req_accel_y;
         az_ff  <= req_accel_z;
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sqz_ff <= sqz_in;
      end
   end

   // Scale down, form the squared norms and flag a zero accelerometer vector.
   always_comb begin
      r2           = $unsigned(sqy_ff) + $unsigned(sqz_ff);
      n2           = $unsigned(sqx_ff) + r2;
      q_item.ax    = ax_ff;
      q_item.ay    = ay_ff;
      q_item.az    = az_ff;
      q_item.mx    = MAG_W'(px_ff >>> 14);
      q_item.my    = MAG_W'(py_ff >>> 14);
      q_item.mz    = MAG_W'(pz_ff >>> 14);
      q_item.n2    = n2;
      q_item.r2    = r2;
      q_item.degen = (n2 == '0);
   end

endmodule

@@ rtl/tch_queue.sv @@
module tch_queue import tch_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   input  logic       pop,
   output q_item_type head_item,
   output logic       full,
   output logic       empty
);

   q_item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/tch_sqrt.sv @@
module tch_sqrt import tch_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff [ROOT_W];
   logic [RAD_W-1:0] res_ff [ROOT_W];

   // One result bit per stage, restoring square root.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RAD_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);

      if (k == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[ROOT_W-1][ROOT_W-1:0];

endmodule

@@ rtl/tch_cordic.sv @@
module tch_cordic import tch_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [XY_W-1:0] x_in,
   input  logic signed [XY_W-1:0] y_in,
   input  logic                   degen_in,
   output logic signed [Z_W-1:0]  z_out,
   output logic                   clear_out,
   output logic                   degen_out
);

   cordic_type st_ff [CORDIC_STAGES + 1];
   cordic_type pre_in;

   // Fold the left half-plane over and note a zero vector.
   always_comb begin
      pre_in.clear = degen_in || ((x_in == '0) && (y_in == '0));
      pre_in.degen = degen_in;
      if (x_in < 0) begin
         pre_in.x = -x_in;
         pre_in.y = -y_in;
         pre_in.z = Z_W'(Z_HALF_TURN);
      end else begin
         pre_in.x = x_in;
         pre_in.y = y_in;
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= pre_in;
      end
   end

   // Vectoring rotations toward the x axis.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      cordic_type rot_in;
      logic signed [XY_W-1:0] xs, ys;

      always_comb begin
         xs     = st_ff[i].x >>> i;
         ys     = st_ff[i].y >>> i;
         rot_in = st_ff[i];
         if (st_ff[i].y >= 0) begin
            rot_in.x = st_ff[i].x + ys;
            rot_in.y = st_ff[i].y - xs;
            rot_in.z = st_ff[i].z + atan_q20(i);
         end else begin
            rot_in.x = st_ff[i].x - ys;
            rot_in.y = st_ff[i].y + xs;
            rot_in.z = st_ff[i].z - atan_q20(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i+1] <= rot_in;
         end
      end
   end

   assign z_out     = st_ff[CORDIC_STAGES].z;
   assign clear_out = st_ff[CORDIC_STAGES].clear;
   assign degen_out = st_ff[CORDIC_STAGES].degen;

endmodule

@@ rtl/tch_back.sv @@
module tch_back import tch_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  q_item_type           q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [HEADING_W-1:0] rsp_heading,
   output logic                 rsp_degenerate
);

   localparam logic signed [HR_W-1:0] FULL_S = HR_W'(HEAD_FULL);

   logic [BACK_DEPTH-1:0] vld_ff;
   logic                  adv;
   q_item_type            side_ff [ROOT_W];
   logic [ROOT_W-1:0]     n_root, r_root;
   q_item_type            sq;

   // First multiply stage.
   logic signed [ROOT_W:0]   n_s, r_s;
   logic signed [SAMPLE_W:0] abs_az;
   logic signed [35:0] m1_mxr_ff, m1_myaz_ff;
   logic signed [34:0] m1_mzax_ff, m1_mxax_ff, m1_mzay_ff;
   logic signed [ROOT_W:0]   m1_n_ff, m1_r_ff;
   logic signed [SAMPLE_W-1:0] m1_ay_ff;
   logic signed [MAG_W-1:0]  m1_my_ff;
   logic                     m1_rzero_ff, m1_degen_ff;

   // Second multiply stage.
   logic signed [36:0] m2_xa_ff;
   logic signed [52:0] m2_y1_ff;
   logic signed [50:0] m2_y2_ff;
   logic signed [51:0] m2_y3_ff;
   logic signed [35:0] m2_ymn_ff, m2_nmzax_ff;
   logic signed [ROOT_W:0] m2_r_ff;
   logic                   m2_rzero_ff, m2_degen_ff;

   // Third multiply stage: the horizontal field vector.
   logic signed [XY_W-1:0] m3_x_ff, m3_y_ff, m3_x_in, m3_y_in;
   logic                   m3_degen_ff;

   logic signed [Z_W-1:0]  cz, zsum;
   logic                   cclear, cdegen;
   logic signed [HR_W-1:0] hr, hw;
   logic [HEADING_W-1:0]   rsp_heading_ff, rsp_heading_in;
   logic                   rsp_degenerate_ff;

   assign rsp_valid      = vld_ff[BACK_DEPTH-1];
   assign adv            = !rsp_valid || rsp_ready;
   assign q_pop          = adv && !q_empty;
   assign rsp_heading    = rsp_heading_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

   // One valid bit per pipeline stage; the whole back end moves together.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BACK_DEPTH-2:0], !q_empty};
      end
   end

   tch_sqrt u_sqrt_n (
      .clock    (clock),
      .en       (adv),
      .radicand (q_item.n2),
      .root     (n_root)
   );

   tch_sqrt u_sqrt_r (
      .clock    (clock),
      .en       (adv),
      .radicand (q_item.r2),
      .root     (r_root)
   );

   // Sample data rides alongside the square root stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= q_item;
         for (int k = 1; k < ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign sq = side_ff[ROOT_W-1];

   always_comb begin
      n_s    = $signed({1'b0, n_root});
      r_s    = $signed({1'b0, r_root});
      abs_az = (sq.az < 0) ? -(SAMPLE_W + 1)'(sq.az) : (SAMPLE_W + 1)'(sq.az);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_mxr_ff   <= sq.mx * r_s;
         m1_mzax_ff  <= sq.mz * sq.ax;
         m1_myaz_ff  <= sq.my * abs_az;
         m1_mxax_ff  <= sq.mx * sq.ax;
         m1_mzay_ff  <= sq.mz * sq.ay;
         m1_n_ff     <= n_s;
         m1_r_ff     <= r_s;
         m1_ay_ff    <= sq.ay;
         m1_my_ff    <= sq.my;
         m1_rzero_ff <= (r_root == '0);
         m1_degen_ff <= sq.degen;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_xa_ff    <= 37'(m1_mxr_ff) - 37'(m1_mzax_ff);
         m2_y1_ff    <= m1_myaz_ff * m1_n_ff;
         m2_y2_ff    <= m1_mxax_ff * m1_ay_ff;
         m2_y3_ff    <= m1_mzay_ff * m1_r_ff;
         m2_ymn_ff   <= m1_my_ff * m1_n_ff;
         m2_nmzax_ff <= -36'(m1_mzax_ff);
         m2_r_ff     <= m1_r_ff;
         m2_rzero_ff <= m1_rzero_ff;
         m2_degen_ff <= m1_degen_ff;
      end
   end

   // With no roll reference the field uses pitch alone.
   always_comb begin
      if (m2_rzero_ff) begin
         m3_x_in = XY_W'(m2_nmzax_ff);
         m3_y_in = XY_W'(m2_ymn_ff);
      end else begin
         m3_x_in = XY_W'(m2_xa_ff * m2_r_ff);
         m3_y_in = XY_W'(m2_y1_ff) - XY_W'(m2_y2_ff) - XY_W'(m2_y3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_x_ff     <= m3_x_in;
         m3_y_ff     <= m3_y_in;
         m3_degen_ff <= m2_degen_ff;
      end
   end

   tch_cordic u_cordic (
      .clock     (clock),
      .en        (adv),
      .x_in      (m3_x_ff),
      .y_in      (m3_y_ff),
      .degen_in  (m3_degen_ff),
      .z_out     (cz),
      .clear_out (cclear),
      .degen_out (cdegen)
   );

   // Round half up to the heading step and wrap once into a full turn.
   always_comb begin
      zsum = cz + Z_W'(Z_ROUND);
      hr   = HR_W'(zsum >>> (ZFRAC - ANGLE_FRAC_BITS));
      if (hr < 0) begin
         hw = hr + FULL_S;
      end else if (hr >= FULL_S) begin
         hw = hr - FULL_S;
      end else begin
         hw = hr;
      end
      rsp_heading_in = cclear ? '0 : hw[HEADING_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_heading_ff    <= rsp_heading_in;
         rsp_degenerate_ff <= cdegen;
      end
   end

endmodule

@@ rtl/tilt_compensated_heading_top.sv @@
// Channel   Ports         Direction   Beat
// req       req_*         in          accelerometer and magnetometer triple
// rsp       rsp_*         out         heading and degenerate flag
// csr       csr_*         in          calibration register write, no wait
//
// One beat is taken every cycle when the result side keeps up.
// An accepted req beat passes through one front stage, the queue, a 16-stage
// square root, three multiply stages, CORDIC set-up, 16 CORDIC rotations and
// the output register on its way to its rsp beat.
// Reset is synchronous; offsets clear to zero and scales return to one.
// A stalled rsp holds the back end; the front and a four-beat queue keep
// taking req beats until the queue fills.
module tilt_compensated_heading_top import tch_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic signed [SAMPLE_W-1:0] req_mag_x,
   input  logic signed [SAMPLE_W-1:0] req_mag_y,
   input  logic signed [SAMPLE_W-1:0] req_mag_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [HEADING_W-1:0]       rsp_heading,
   output logic                       rsp_degenerate,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [SAMPLE_W-1:0]        csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   q_item_type push_item, head_item;
   logic       q_push, q_pop, q_full, q_empty;

   // Calibration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_OFFSET_X: cfg_in.offset_x = $signed(csr_wdata);
            CSR_OFFSET_Y: cfg_in.offset_y = $signed(csr_wdata);
            CSR_OFFSET_Z: cfg_in.offset_z = $signed(csr_wdata);
            CSR_SCALE_X:  cfg_in.scale_x  = csr_wdata;
            CSR_SCALE_Y:  cfg_in.scale_y  = csr_wdata;
            CSR_SCALE_Z:  cfg_in.scale_z  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x <= '0;
         cfg_ff.offset_y <= '0;
         cfg_ff.offset_z <= '0;
         cfg_ff.scale_x  <= SAMPLE_W'(SCALE_ONE);
         cfg_ff.scale_y  <= SAMPLE_W'(SCALE_ONE);
         cfg_ff.scale_z  <= SAMPLE_W'(SCALE_ONE);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tch_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .req_mag_x   (req_mag_x),
      .req_mag_y   (req_mag_y),
      .req_mag_z   (req_mag_z),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   tch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   tch_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_heading    (rsp_heading),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

@@ rtl/tch_checker.sv @@
module tch_checker import tch_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [HEADING_W-1:0] rsp_heading,
   input logic                 rsp_degenerate
);

   // A held result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading)
         && $stable(rsp_degenerate))
      else $error("rsp beat changed while stalled");

   // The heading always lies within one turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading < HEADING_W'(HEAD_FULL)))
      else $error("heading outside one turn");

   // A degenerate result carries heading zero.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_heading == '0))
      else $error("degenerate result with nonzero heading");

   // No result comes straight out of reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tilt_compensated_heading_top tch_checker u_tch_checker (.*);
